FILE: hw/rtl/olr_pkg.sv
// Shared types and constants of the object image record loader.
`default_nettype none
package olr_pkg;

  // Width of the internal word address counter; the result address is 16 bits.
  localparam int unsigned AddrBits = 16;
  localparam int unsigned TagW     = 16;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned WordW    = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned QueueDepth = 2;

  localparam logic [TagW-1:0] CodeTagRst       = 16'hCADE;
  localparam logic [TagW-1:0] DataTagRst       = 16'hDADA;
  localparam logic [TagW-1:0] SymbolTagRst     = 16'hC3B7;
  localparam logic [TagW-1:0] FileNameTagRst   = 16'hF17E;
  localparam logic [TagW-1:0] LineNumberTagRst = 16'h715E;

  typedef enum logic [CfgIdxW-1:0] {
    CfgCodeTag       = 3'd0,
    CfgDataTag       = 3'd1,
    CfgSymbolTag     = 3'd2,
    CfgFileNameTag   = 3'd3,
    CfgLineNumberTag = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic               we;
    logic [CfgIdxW-1:0] index;
    logic [TagW-1:0]    data;
  } cfg_wr_t;

  typedef struct packed {
    logic [WordW-1:0] addr;
    logic [WordW-1:0] word;
  } wr_item_t;

endpackage
`default_nettype wire

FILE: hw/rtl/olr_front.sv
// Front end: byte parser that decodes records and produces word writes.
`default_nettype none
module olr_front (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  olr_pkg::cfg_wr_t     cfg_i,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  wire  [7:0]           stream_byte_i,
  input  wire                  q_full_i,
  output logic                 push_o,
  output olr_pkg::wr_item_t    push_item_o
);
  import olr_pkg::*;

  localparam logic [3:0] PhTagHi  = 4'd0;
  localparam logic [3:0] PhTagLo  = 4'd1;
  localparam logic [3:0] PhAddrHi = 4'd2;
  localparam logic [3:0] PhAddrLo = 4'd3;
  localparam logic [3:0] PhWcntHi = 4'd4;
  localparam logic [3:0] PhWcntLo = 4'd5;
  localparam logic [3:0] PhWordHi = 4'd6;
  localparam logic [3:0] PhWordLo = 4'd7;
  localparam logic [3:0] PhSymPre = 4'd8;
  localparam logic [3:0] PhScntHi = 4'd9;
  localparam logic [3:0] PhScntLo = 4'd10;
  localparam logic [3:0] PhSkip   = 4'd11;

  logic [TagW-1:0]     code_tag_q, data_tag_q, symbol_tag_q, file_name_tag_q, line_tag_q;
  logic [3:0]          phase_q, phase_d;
  logic [ByteW-1:0]    held_q, held_d;
  logic [AddrBits-1:0] addr_q, addr_d;
  logic [WordW-1:0]    cnt_q, cnt_d;
  logic [WordW-1:0]    joined;
  logic [WordW-1:0]    cnt_dec;
  logic                accept;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_tag_q      <= CodeTagRst;
      data_tag_q      <= DataTagRst;
      symbol_tag_q    <= SymbolTagRst;
      file_name_tag_q <= FileNameTagRst;
      line_tag_q      <= LineNumberTagRst;
    end else if (cfg_i.we) begin
      case (cfg_i.index)
        CfgCodeTag:       code_tag_q      <= cfg_i.data;
        CfgDataTag:       data_tag_q      <= cfg_i.data;
        CfgSymbolTag:     symbol_tag_q    <= cfg_i.data;
        CfgFileNameTag:   file_name_tag_q <= cfg_i.data;
        CfgLineNumberTag: line_tag_q      <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign joined     = {held_q, stream_byte_i};
  assign cnt_dec    = cnt_q - 16'd1;

  always_comb begin
    phase_d     = phase_q;
    held_d      = held_q;
    addr_d      = addr_q;
    cnt_d       = cnt_q;
    push_o      = 1'b0;
    push_item_o.addr = 16'(addr_q);
    push_item_o.word = joined;
    if (accept) begin
      case (phase_q)
        PhTagLo: begin
          // First matching tag wins.
          if (joined == code_tag_q || joined == data_tag_q) begin
            phase_d = PhAddrHi;
          end else if (joined == symbol_tag_q) begin
            cnt_d   = 16'd2;
            phase_d = PhSymPre;
          end else if (joined == file_name_tag_q) begin
            phase_d = PhScntHi;
          end else if (joined == line_tag_q) begin
            cnt_d   = 16'd6;
            phase_d = PhSkip;
          end else begin
            phase_d = PhTagHi;
          end
        end
        PhAddrHi, PhWcntHi, PhWordHi, PhScntHi: begin
          held_d  = stream_byte_i;
          phase_d = phase_q + 4'd1;
        end
        PhAddrLo: begin
          addr_d  = AddrBits'(joined);
          phase_d = PhWcntHi;
        end
        PhWcntLo: begin
          cnt_d   = joined;
          phase_d = (joined == '0) ? PhTagHi : PhWordHi;
        end
        PhWordLo: begin
          push_o  = 1'b1;
          addr_d  = addr_q + AddrBits'(1);
          cnt_d   = cnt_dec;
          phase_d = (cnt_dec == '0) ? PhTagHi : PhWordHi;
        end
        PhSymPre: begin
          cnt_d = cnt_dec;
          if (cnt_dec == '0) begin
            phase_d = PhScntHi;
          end
        end
        PhScntLo: begin
          cnt_d   = joined;
          phase_d = (joined == '0) ? PhTagHi : PhSkip;
        end
        PhSkip: begin
          cnt_d = cnt_dec;
          if (cnt_dec == '0) begin
            phase_d = PhTagHi;
          end
        end
        default: begin
          // Tag high byte, and any unused code.
          held_d  = stream_byte_i;
          phase_d = PhTagLo;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhTagHi;
      held_q  <= '0;
      addr_q  <= '0;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      held_q  <= held_d;
      addr_q  <= addr_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/olr_queue.sv
// Short queue of word writes between the parser and the output stage.
`default_nettype none
module olr_queue (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                push_i,
  input  olr_pkg::wr_item_t  push_item_i,
  output logic               full_o,
  output logic               valid_o,
  input  wire                pop_i,
  output olr_pkg::wr_item_t  head_o
);
  import olr_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  wr_item_t          slot_q [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + CntW'(1);
        2'b01:   cnt_q <= cnt_q - CntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/olr_back.sv
// Back end: output register that presents word writes to the receiver.
`default_nettype none
module olr_back (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                q_valid_i,
  input  olr_pkg::wr_item_t  q_head_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output logic [15:0]        write_address_o,
  output logic [15:0]        write_word_o
);
  import olr_pkg::*;

  logic     valid_q;
  wr_item_t item_q;

  // Load a new item when the register is empty or being drained.
  assign q_pop_o = q_valid_i && (!valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!valid_q || out_ready_i) begin
      valid_q <= q_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      item_q <= q_head_i;
    end
  end

  assign out_valid_o     = valid_q;
  assign write_address_o = item_q.addr;
  assign write_word_o    = item_q.word;

endmodule
`default_nettype wire

FILE: hw/rtl/object_image_record_loader_unit.sv
// Top level of the object image record loader.
// Usage:
//   Input channel (in_valid_i / in_ready_o / stream_byte_i) carries the
//   object image, one byte per item, big-endian values throughout.
//   Output channel (out_valid_o / out_ready_i) carries word writes,
//   write_address_o and write_word_o, one item per data word of a code or
//   data record; other records and unknown tags are consumed without output.
//   Configuration: cfg_we_i writes cfg_data_i into tag register cfg_index_i
//   (0 code, 1 data, 2 symbol, 3 file name, 4 line number); higher indexes
//   are ignored. Write only while the block is idle.
// Timing:
//   One byte per cycle while the queue has a free slot; the parser decides
//   each byte as it is accepted. A word write enters the queue at the edge
//   that accepts its low byte and reaches the output through the output register.
//   Input ready depends only on the two-entry queue having a free slot.
// Reset: asynchronous, active low; tags return to their defaults,
//   the parser waits for a tag and the queue and output register empty.
// Stall: when the receiver holds out_ready_i low, hold the output item,
//   fill the queue, and after two more words stop taking bytes.
`default_nettype none
module object_image_record_loader_unit (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire  [7:0]  stream_byte_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [15:0] write_address_o,
  output logic [15:0] write_word_o,
  input  wire         cfg_we_i,
  input  wire  [2:0]  cfg_index_i,
  input  wire  [15:0] cfg_data_i
);
  import olr_pkg::*;

  cfg_wr_t  cfg;
  wr_item_t push_item, head_item;
  logic     push, q_full, q_valid, q_pop;

  assign cfg.we    = cfg_we_i;
  assign cfg.index = cfg_index_i;
  assign cfg.data  = cfg_data_i;

  // Parse bytes and emit a word write on each data word low byte.
  olr_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .stream_byte_i (stream_byte_i),
    .q_full_i      (q_full),
    .push_o        (push),
    .push_item_o   (push_item)
  );

  // Decouple parser from receiver backpressure.
  olr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .pop_i       (q_pop),
    .head_o      (head_item)
  );

  // Present writes to the receiver.
  olr_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_head_i        (head_item),
    .q_pop_o         (q_pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .write_address_o (write_address_o),
    .write_word_o    (write_word_o)
  );

endmodule
`default_nettype wire

FILE: hw/rtl/olr_checker.sv
// Port-level checks of the object image record loader, bound to the top level.
`default_nettype none
module olr_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        in_ready_o,
  input wire        out_valid_o,
  input wire        out_ready_i,
  input wire [15:0] write_address_o,
  input wire [15:0] write_word_o
);

  // Output stays valid while stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output item dropped while stalled");

  // Stalled output item holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(write_address_o) && $stable(write_word_o))
    else $error("output item changed while stalled");

  // Input backpressure only arises while an output item is pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no output item pending");

  // Nothing is offered during reset.
  assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

endmodule

bind object_image_record_loader_unit olr_checker u_olr_checker (.*);
`default_nettype wire

FILE: verif/tb_object_image_record_loader_unit.sv
// Testbench for the object image record loader: byte stream in, word writes out.

typedef enum logic [3:0] {
  PhTagHi,
  PhTagLo,
  PhAddrHi,
  PhAddrLo,
  PhCountHi,
  PhCountLo,
  PhWordHi,
  PhWordLo,
  PhSymbolPre,
  PhSkipCountHi,
  PhSkipCountLo,
  PhSkip
} parse_phase_e;

typedef enum logic [2:0] {
  KindLoad,
  KindSymbol,
  KindFileName,
  KindLine,
  KindUnknown
} record_kind_e;

// Track the parser byte by byte and hold the word writes still owed by the block.
class record_parser_model;
  logic [15:0]       code_tag;
  logic [15:0]       data_tag;
  logic [15:0]       symbol_tag;
  logic [15:0]       file_name_tag;
  logic [15:0]       line_number_tag;
  parse_phase_e      phase;
  logic [7:0]        held_byte;
  logic [15:0]       next_addr;
  logic [15:0]       remaining;
  olr_pkg::wr_item_t pending_writes[$];
  int unsigned       fail_count;

  function new();
    code_tag        = olr_pkg::CodeTagRst;
    data_tag        = olr_pkg::DataTagRst;
    symbol_tag      = olr_pkg::SymbolTagRst;
    file_name_tag   = olr_pkg::FileNameTagRst;
    line_number_tag = olr_pkg::LineNumberTagRst;
    phase           = PhTagHi;
    held_byte       = '0;
    next_addr       = '0;
    remaining       = '0;
    fail_count      = 0;
  endfunction

  function void write_tag(logic [olr_pkg::CfgIdxW-1:0] idx, logic [15:0] value);
    case (idx)
      olr_pkg::CfgCodeTag:       code_tag = value;
      olr_pkg::CfgDataTag:       data_tag = value;
      olr_pkg::CfgSymbolTag:     symbol_tag = value;
      olr_pkg::CfgFileNameTag:   file_name_tag = value;
      olr_pkg::CfgLineNumberTag: line_number_tag = value;
      default: ;
    endcase
  endfunction

  // First match wins, in the order code, data, symbol, file name, line number.
  function record_kind_e kind_of(logic [15:0] tag);
    if (tag == code_tag || tag == data_tag) return KindLoad;
    if (tag == symbol_tag) return KindSymbol;
    if (tag == file_name_tag) return KindFileName;
    if (tag == line_number_tag) return KindLine;
    return KindUnknown;
  endfunction

  function void take_byte(logic [7:0] b);
    logic [15:0]       joined;
    olr_pkg::wr_item_t item;
    joined = {held_byte, b};
    case (phase)
      PhTagLo: begin
        case (kind_of(joined))
          KindLoad: phase = PhAddrHi;
          KindSymbol: begin
            remaining = 16'd2;
            phase = PhSymbolPre;
          end
          KindFileName: phase = PhSkipCountHi;
          KindLine: begin
            remaining = 16'd6;
            phase = PhSkip;
          end
          default: phase = PhTagHi;
        endcase
      end
      PhAddrHi: begin
        held_byte = b;
        phase = PhAddrLo;
      end
      PhCountHi: begin
        held_byte = b;
        phase = PhCountLo;
      end
      PhWordHi: begin
        held_byte = b;
        phase = PhWordLo;
      end
      PhSkipCountHi: begin
        held_byte = b;
        phase = PhSkipCountLo;
      end
      PhAddrLo: begin
        next_addr = joined;
        phase = PhCountHi;
      end
      PhCountLo: begin
        remaining = joined;
        phase = (remaining == 0) ? PhTagHi : PhWordHi;
      end
      PhWordLo: begin
        item.addr = next_addr;
        item.word = joined;
        pending_writes.push_back(item);
        next_addr = next_addr + 16'd1;
        remaining = remaining - 16'd1;
        phase = (remaining == 0) ? PhTagHi : PhWordHi;
      end
      PhSymbolPre: begin
        remaining = remaining - 16'd1;
        if (remaining == 0) phase = PhSkipCountHi;
      end
      PhSkipCountLo: begin
        remaining = joined;
        phase = (remaining == 0) ? PhTagHi : PhSkip;
      end
      PhSkip: begin
        remaining = remaining - 16'd1;
        if (remaining == 0) phase = PhTagHi;
      end
      default: begin
        held_byte = b;
        phase = PhTagLo;
      end
    endcase
  endfunction

  function void check_write(logic [15:0] addr, logic [15:0] word);
    olr_pkg::wr_item_t want;
    if (pending_writes.size() == 0) begin
      $display("%0t: write with none owed: address %h word %h", $time, addr, word);
      fail_count++;
      return;
    end
    want = pending_writes.pop_front();
    if (want.addr !== addr) begin
      $display("%0t: write_address expected %h actual %h", $time, want.addr, addr);
      fail_count++;
    end
    if (want.word !== word) begin
      $display("%0t: write_word expected %h actual %h", $time, want.word, word);
      fail_count++;
    end
  endfunction
endclass

module tb_object_image_record_loader_unit;

  localparam int unsigned SettleCycles  = 6;
  localparam int unsigned HoldOffCycles = 80;
  localparam int unsigned CycleLimit    = 1000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  stream_byte_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [15:0] write_address_o;
  logic [15:0] write_word_o;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  record_parser_model parser_model = new();
  logic [7:0]         image_bytes[$];
  int unsigned        cycle_count = 0;
  bit                 steady_phase = 1'b0;
  bit                 hold_off_req = 1'b0;

  object_image_record_loader_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .stream_byte_i   (stream_byte_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .write_address_o (write_address_o),
    .write_word_o    (write_word_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Abort a hung run; the limit sits far above the slowest legal run.
  always @(posedge clk_i) begin : watchdog
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Sample both channels at the rising edge; bytes go in before writes are checked,
  // so a write can never be seen ahead of the byte that caused it.
  always @(posedge clk_i) begin : monitor
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) parser_model.take_byte(stream_byte_i);
      if (out_valid_o && out_ready_i) parser_model.check_write(write_address_o, write_word_o);
    end
  end

  // Mostly back to back, sometimes a short pause, rarely a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (steady_phase) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Receiver: stall at random; on request hold off for a long stretch so the
  // block backs up and stops taking bytes.
  initial begin : receiver
    int unsigned stall;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall = HoldOffCycles;
      end else begin
        stall = pick_gap();
      end
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  function automatic void push_word(logic [15:0] value);
    image_bytes.push_back(value[15:8]);
    image_bytes.push_back(value[7:0]);
  endfunction

  function automatic void add_load_record(logic [15:0] tag, logic [15:0] start,
                                          int unsigned words);
    push_word(tag);
    push_word(start);
    push_word(16'(words));
    repeat (words) push_word(16'($urandom));
  endfunction

  function automatic int unsigned pick_count();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) return 0;
    if (roll < 85) return $urandom_range(1, 4);
    return $urandom_range(5, 24);
  endfunction

  // Pick a tag, then lay the record out as the current tag settings decode it,
  // so shadowed tags still give well-formed streams.
  function automatic void add_random_record();
    logic [15:0] tag;
    logic [15:0] start;
    int unsigned roll;
    int unsigned count;
    roll = $urandom_range(0, 99);
    if (roll < 40) tag = parser_model.code_tag;
    else if (roll < 60) tag = parser_model.data_tag;
    else if (roll < 72) tag = parser_model.symbol_tag;
    else if (roll < 82) tag = parser_model.file_name_tag;
    else if (roll < 90) tag = parser_model.line_number_tag;
    else begin
      do tag = 16'($urandom); while (parser_model.kind_of(tag) != KindUnknown);
    end
    count = pick_count();
    case (parser_model.kind_of(tag))
      KindLoad: begin
        start = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(16'hFFF8, 16'hFFFF))
                                           : 16'($urandom);
        add_load_record(tag, start, count);
      end
      KindSymbol: begin
        push_word(tag);
        push_word(16'($urandom));
        push_word(16'(count));
        repeat (count) image_bytes.push_back(8'($urandom));
      end
      KindFileName: begin
        push_word(tag);
        push_word(16'(count));
        repeat (count) image_bytes.push_back(8'($urandom));
      end
      KindLine: begin
        push_word(tag);
        repeat (3) push_word(16'($urandom));
      end
      default: push_word(tag);
    endcase
  endfunction

  // Offer queued bytes one per item; hold valid and data until taken.
  // Called and returns at a falling edge.
  task automatic send_image();
    int unsigned gap;
    while (image_bytes.size() != 0) begin
      gap = pick_gap();
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      in_valid_i    <= 1'b1;
      stream_byte_i <= image_bytes.pop_front();
      @(posedge clk_i);
      while (!in_ready_o) @(posedge clk_i);
      @(negedge clk_i);
    end
    in_valid_i <= 1'b0;
  endtask

  // Fill the image up to the budget, send it, and drain every owed write.
  task automatic run_phase(int unsigned byte_budget);
    while (image_bytes.size() < byte_budget) add_random_record();
    send_image();
    while (parser_model.pending_writes.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Write one tag register; leaves the write enable high for the caller to drop,
  // so back-to-back writes never lower and raise it in one step.
  task automatic write_tag(logic [olr_pkg::CfgIdxW-1:0] idx, logic [15:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    parser_model.write_tag(idx, value);
    @(negedge clk_i);
  endtask

  initial begin : stimulus
    logic [15:0] shared_a;
    logic [15:0] shared_b;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: wrap the address past the top, extreme words, an unknown tag,
    // a zero-count data record and a line-number record, all on reset tags.
    add_load_record(olr_pkg::CodeTagRst, 16'hFFFF, 2);
    image_bytes[image_bytes.size()-4] = 8'h00;
    image_bytes[image_bytes.size()-3] = 8'h00;
    image_bytes[image_bytes.size()-2] = 8'hFF;
    image_bytes[image_bytes.size()-1] = 8'hFF;
    push_word(16'h0000);
    add_load_record(olr_pkg::DataTagRst, 16'h1234, 0);
    push_word(olr_pkg::LineNumberTagRst);
    push_word(16'hFFFF);
    push_word(16'h0000);
    push_word(16'hA55A);
    run_phase(250);

    // Extreme tag values, plus writes to unused indexes that must be dropped.
    write_tag(olr_pkg::CfgCodeTag, 16'h0000);
    write_tag(olr_pkg::CfgDataTag, 16'hFFFF);
    write_tag(olr_pkg::CfgSymbolTag, 16'h8001);
    write_tag(olr_pkg::CfgFileNameTag, 16'h7FFE);
    write_tag(olr_pkg::CfgLineNumberTag, 16'($urandom));
    write_tag(olr_pkg::CfgIdxW'($urandom_range((1 << olr_pkg::CfgIdxW) - 1,
                                               olr_pkg::CfgLineNumberTag + 1)),
              16'($urandom));
    write_tag(olr_pkg::CfgIdxW'((1 << olr_pkg::CfgIdxW) - 1), 16'h0000);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    run_phase(250);

    // Shadowed tags: symbol equals code and file name equals data, so the
    // earlier tag in priority order must win.
    shared_a = 16'($urandom);
    do shared_b = 16'($urandom); while (shared_b == shared_a);
    write_tag(olr_pkg::CfgCodeTag, shared_a);
    write_tag(olr_pkg::CfgSymbolTag, shared_a);
    write_tag(olr_pkg::CfgDataTag, shared_b);
    write_tag(olr_pkg::CfgFileNameTag, shared_b);
    write_tag(olr_pkg::CfgLineNumberTag, 16'($urandom));
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    run_phase(250);

    // Random tags under back-pressure, with one long record that wraps the address.
    write_tag(olr_pkg::CfgCodeTag, 16'($urandom));
    write_tag(olr_pkg::CfgDataTag, 16'($urandom));
    write_tag(olr_pkg::CfgSymbolTag, 16'($urandom));
    write_tag(olr_pkg::CfgFileNameTag, 16'($urandom));
    write_tag(olr_pkg::CfgLineNumberTag, 16'($urandom));
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    repeat (6) add_random_record();
    add_load_record(parser_model.code_tag, 16'hFF80, 260);
    hold_off_req = 1'b1;
    run_phase(550);

    // Back to the reset tags, sent back to back with no idling.
    write_tag(olr_pkg::CfgCodeTag, olr_pkg::CodeTagRst);
    write_tag(olr_pkg::CfgDataTag, olr_pkg::DataTagRst);
    write_tag(olr_pkg::CfgSymbolTag, olr_pkg::SymbolTagRst);
    write_tag(olr_pkg::CfgFileNameTag, olr_pkg::FileNameTagRst);
    write_tag(olr_pkg::CfgLineNumberTag, olr_pkg::LineNumberTagRst);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    steady_phase = 1'b1;
    run_phase(250);

    if (parser_model.fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
